>>> hdl/tli_pkg.sv
// tli_pkg: shared types and constants for the table linear interpolator.
// Controller states, datapath command/status words, fixed field widths.
// No dependencies.
package tli_pkg;

  localparam int unsigned XW        = 32;  // Q16.16 word width
  localparam int unsigned IDX_W     = 10;  // load index width
  localparam int unsigned CNT_W     = 11;  // entry_count register width
  localparam int unsigned DIV_STEPS = 34;  // quotient bits produced by the divider
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd2;
  localparam logic [CNT_W-1:0] CNT_MIN   = 11'd2;

  localparam logic [XW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] Q_MIN = 32'h8000_0000;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RANGE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SEG_HI,
    ST_DIFF,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  // table read address select
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_LO1
  } rd_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    logic    load_wr;
    logic    cap_query;
    logic    chk_low;
    logic    chk_high;
    logic    srch_init;
    logic    srch_upd;
    logic    cap_seg0;
    logic    cap_seg1;
    logic    mul;
    logic    prep;
    logic    div_step;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic outside;
    logic narrow;
    logic skip_div;
  } sts_t;

endpackage

>>> hdl/tli_ctrl.sv
// tli_ctrl: sequencer for load, range check, binary search, multiply and divide.
// Drives tli_dp through cmd_t and reads sts_t back. Uses tli_pkg.
module tli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_action,
  input  tli_pkg::sts_t sts,
  output tli_pkg::cmd_t cmd,
  output logic          busy
);

  tli_pkg::state_t state_r, state_nxt;
  logic [tli_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic accept;

  assign busy   = (state_r != tli_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tli_pkg::ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    case (state_r)
      tli_pkg::ST_IDLE: begin
        if (accept && in_action == tli_pkg::ACT_QUERY) state_nxt = tli_pkg::ST_RD_LAST;
      end
      tli_pkg::ST_RD_LAST: state_nxt = tli_pkg::ST_RANGE;
      tli_pkg::ST_RANGE: begin
        state_nxt = sts.outside ? tli_pkg::ST_FINISH : tli_pkg::ST_SRCH_RD;
      end
      tli_pkg::ST_SRCH_RD: begin
        state_nxt = sts.narrow ? tli_pkg::ST_SEG_HI : tli_pkg::ST_SRCH_CMP;
      end
      tli_pkg::ST_SRCH_CMP: state_nxt = tli_pkg::ST_SRCH_RD;
      tli_pkg::ST_SEG_HI:   state_nxt = tli_pkg::ST_DIFF;
      tli_pkg::ST_DIFF:     state_nxt = tli_pkg::ST_MUL;
      tli_pkg::ST_MUL:      state_nxt = tli_pkg::ST_PREP;
      tli_pkg::ST_PREP: begin
        div_cnt_nxt = tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1);
        state_nxt   = sts.skip_div ? tli_pkg::ST_FINISH : tli_pkg::ST_DIV;
      end
      tli_pkg::ST_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = tli_pkg::ST_FINISH;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      tli_pkg::ST_FINISH: state_nxt = tli_pkg::ST_IDLE;
      default:            state_nxt = tli_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = tli_pkg::RD_ZERO;
    case (state_r)
      tli_pkg::ST_IDLE: begin
        cmd.load_wr   = accept && (in_action == tli_pkg::ACT_LOAD);
        cmd.cap_query = accept && (in_action == tli_pkg::ACT_QUERY);
      end
      tli_pkg::ST_RD_LAST: begin
        cmd.rd_sel  = tli_pkg::RD_LAST;
        cmd.chk_low = 1'b1;
      end
      tli_pkg::ST_RANGE: begin
        cmd.chk_high  = 1'b1;
        cmd.srch_init = 1'b1;
      end
      tli_pkg::ST_SRCH_RD: begin
        cmd.rd_sel = sts.narrow ? tli_pkg::RD_LO : tli_pkg::RD_MID;
      end
      tli_pkg::ST_SRCH_CMP: cmd.srch_upd = 1'b1;
      tli_pkg::ST_SEG_HI: begin
        cmd.rd_sel   = tli_pkg::RD_LO1;
        cmd.cap_seg0 = 1'b1;
      end
      tli_pkg::ST_DIFF:   cmd.cap_seg1 = 1'b1;
      tli_pkg::ST_MUL:    cmd.mul      = 1'b1;
      tli_pkg::ST_PREP:   cmd.prep     = 1'b1;
      tli_pkg::ST_DIV:    cmd.div_step = 1'b1;
      tli_pkg::ST_FINISH: cmd.finish   = 1'b1;
      default: ;
    endcase
  end

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tli_pkg::ST_IDLE && start && in_action == tli_pkg::ACT_QUERY)
      |=> state_r == tli_pkg::ST_RD_LAST)
    else $error("accepted query did not start the sequence");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tli_pkg::ST_IDLE && start && in_action == tli_pkg::ACT_LOAD)
      |=> state_r == tli_pkg::ST_IDLE)
    else $error("load word left the controller busy");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tli_pkg::ST_PREP && !sts.skip_div)
      |=> (state_r == tli_pkg::ST_DIV &&
           div_cnt_r == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1)))
    else $error("divider not armed with full step count");

endmodule

>>> hdl/tli_dp.sv
// tli_dp: table memories, search pointers, multiplier, restoring divider and
// saturating result stage. Driven by tli_ctrl via cmd_t. Uses tli_pkg.
module tli_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tli_pkg::cmd_t                    cmd,
  output tli_pkg::sts_t                    sts,
  input  logic [tli_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [tli_pkg::XW-1:0]    in_entry_x,
  input  logic signed [tli_pkg::XW-1:0]    in_entry_y,
  input  logic signed [tli_pkg::XW-1:0]    in_query_x,
  input  logic                             cfg_we,
  input  logic [tli_pkg::CNT_W-1:0]        cfg_entry_count,
  output logic                             out_valid,
  output logic signed [tli_pkg::XW-1:0]    out_value,
  output logic                             out_in_range
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  logic [31:0] mem_x [TABLE_DEPTH];
  logic [31:0] mem_y [TABLE_DEPTH];

  logic [tli_pkg::CNT_W-1:0] cnt_r;
  logic [AW-1:0]             last_idx;
  logic [AW-1:0]             wr_addr;
  logic                      wr_en;
  logic [AW-1:0]             rd_addr;
  logic signed [31:0]        rd_x_r, rd_y_r;

  logic signed [31:0] qx_r;
  logic               below_r, outside_r;
  logic               gt_w;
  logic [AW-1:0]      lo_r, hi_r;
  logic [AW:0]        mid_sum;
  logic [AW-1:0]      mid;
  logic [AW-1:0]      span;

  logic signed [31:0] x0_r, y0_r;
  logic [32:0]        dx_w, dy_w, dq_w;
  logic [31:0]        dxm_r, dym_r, dqm_r;
  logic               neg_r, flat_r, ovf_r;
  logic [63:0]        prod_r;
  logic               ovf_w;

  logic [31:0]        rem_r;
  logic [tli_pkg::DIV_STEPS-1:0] quo_r;
  logic [32:0]        trial;
  logic               ge;

  logic [35:0]        sum_w;
  logic [31:0]        value_w;
  logic               range_w;
  logic               out_valid_r;
  logic [31:0]        out_value_r;
  logic               out_in_range_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= tli_pkg::CNT_RESET;
    end else if (cfg_we) begin
      cnt_r <= cfg_entry_count;
    end
  end

  // clamp count to [2, TABLE_DEPTH], index of last used entry
  always_comb begin
    if (cnt_r < tli_pkg::CNT_MIN) begin
      last_idx = AW'(1);
    end else if (32'(cnt_r) > TABLE_DEPTH) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(cnt_r - 1'b1);
    end
  end

  assign wr_addr = AW'(in_entry_index);
  assign wr_en   = cmd.load_wr && (32'(in_entry_index) < TABLE_DEPTH);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign span    = hi_r - lo_r;

  always_comb begin
    case (cmd.rd_sel)
      tli_pkg::RD_ZERO: rd_addr = '0;
      tli_pkg::RD_LAST: rd_addr = last_idx;
      tli_pkg::RD_MID:  rd_addr = mid;
      tli_pkg::RD_LO:   rd_addr = lo_r;
      tli_pkg::RD_LO1:  rd_addr = lo_r + 1'b1;
      default:          rd_addr = '0;
    endcase
  end

  // table memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_entry_x;
      mem_y[wr_addr] <= in_entry_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  // range check and search
  assign gt_w = (qx_r > rd_x_r);

  assign sts.outside  = below_r | gt_w;
  assign sts.narrow   = (span[AW-1:1] == '0);
  assign sts.skip_div = flat_r | ovf_w;

  always_ff @(posedge clk) begin
    if (cmd.cap_query) qx_r <= in_query_x;
    if (cmd.chk_low)   below_r <= (qx_r < rd_x_r);
    if (cmd.chk_high)  outside_r <= below_r | gt_w;
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= last_idx;
    end else if (cmd.srch_upd) begin
      if (gt_w) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
  end

  // segment differences, all magnitudes fit in 32 bits
  assign dx_w = {rd_x_r[31], rd_x_r} - {x0_r[31], x0_r};
  assign dy_w = {rd_y_r[31], rd_y_r} - {y0_r[31], y0_r};
  assign dq_w = {qx_r[31], qx_r}     - {x0_r[31], x0_r};

  always_ff @(posedge clk) begin
    if (cmd.cap_seg0) begin
      x0_r <= rd_x_r;
      y0_r <= rd_y_r;
    end
    if (cmd.cap_seg1) begin
      dxm_r  <= mag33(dx_w);
      dym_r  <= mag33(dy_w);
      dqm_r  <= mag33(dq_w);
      neg_r  <= dx_w[32] ^ dy_w[32] ^ dq_w[32];
      flat_r <= (dx_w == '0);
    end
    if (cmd.mul) prod_r <= dym_r * dqm_r;
  end

  // quotient needs more than DIV_STEPS bits when the top of the product >= divisor
  assign ovf_w = ({2'b00, prod_r[63:tli_pkg::DIV_STEPS]} >= dxm_r);

  assign trial = {rem_r, quo_r[tli_pkg::DIV_STEPS-1]};
  assign ge    = (trial >= {1'b0, dxm_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ovf_r <= ovf_w;
      rem_r <= {2'b00, prod_r[63:tli_pkg::DIV_STEPS]};
      quo_r <= prod_r[tli_pkg::DIV_STEPS-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? 32'(trial - {1'b0, dxm_r}) : trial[31:0];
      quo_r <= {quo_r[tli_pkg::DIV_STEPS-2:0], ge};
    end
  end

  // result: y0 +/- q, saturated
  assign sum_w = neg_r ? ({{4{y0_r[31]}}, y0_r} - {2'b00, quo_r})
                       : ({{4{y0_r[31]}}, y0_r} + {2'b00, quo_r});

  always_comb begin
    range_w = 1'b1;
    if (outside_r) begin
      value_w = '0;
      range_w = 1'b0;
    end else if (flat_r) begin
      value_w = y0_r;
    end else if (ovf_r || quo_r[tli_pkg::DIV_STEPS-1]) begin
      value_w = neg_r ? tli_pkg::Q_MIN : tli_pkg::Q_MAX;
    end else if (sum_w[35:31] != {5{sum_w[35]}}) begin
      value_w = sum_w[35] ? tli_pkg::Q_MIN : tli_pkg::Q_MAX;
    end else begin
      value_w = sum_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_value_r    <= value_w;
      out_in_range_r <= range_w;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_in_range = out_in_range_r;

  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.srch_upd || cmd.cap_seg0) |-> (lo_r < hi_r))
    else $error("search pointers crossed");

  a_cmp_not_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.srch_upd |-> !sts.narrow)
    else $error("compare step on a one-segment window");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

endmodule

>>> hdl/table_linear_interpolator.sv
// Query: busy stays high through the range check, a search of s <= ceil(log2(n-1)) steps
// (n = clamped entry_count), the multiply and the divide; out_valid pulses as busy drops,
// and no new word is accepted while busy is high. The 34-step restoring divider takes most
// of a query's busy time; a zero-width or overflowing segment skips it, and a query outside
// the table goes straight from the range check to the result. A load word leaves busy low.
// Sync reset sets entry_count to 2; table contents are undefined until loaded. Results cannot be stalled.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [tli_pkg::IDX_W-1:0]     in_entry_index,
  input  logic signed [tli_pkg::XW-1:0] in_entry_x,
  input  logic signed [tli_pkg::XW-1:0] in_entry_y,
  input  logic signed [tli_pkg::XW-1:0] in_query_x,
  input  logic                          cfg_we,
  input  logic [tli_pkg::CNT_W-1:0]     cfg_entry_count,
  output logic                          out_valid,
  output logic signed [tli_pkg::XW-1:0] out_value,
  output logic                          out_in_range
);

  tli_pkg::cmd_t cmd;
  tli_pkg::sts_t sts;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_entry_index  (in_entry_index),
    .in_entry_x      (in_entry_x),
    .in_entry_y      (in_entry_y),
    .in_query_x      (in_query_x),
    .cfg_we          (cfg_we),
    .cfg_entry_count (cfg_entry_count),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_in_range    (out_in_range)
  );

endmodule

>>> bench/tli_checker.sv
// tli_checker: watches the command, config and result channels of the table
// interpolator, keeps its own table and entry count, predicts each query and
// compares every result word. Depends on tli_pkg.
module tli_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_action,
  input  logic [tli_pkg::IDX_W-1:0]     in_entry_index,
  input  logic signed [tli_pkg::XW-1:0] in_entry_x,
  input  logic signed [tli_pkg::XW-1:0] in_entry_y,
  input  logic signed [tli_pkg::XW-1:0] in_query_x,
  input  logic                          cfg_we,
  input  logic [tli_pkg::CNT_W-1:0]     cfg_entry_count,
  input  logic                          out_valid,
  input  logic signed [tli_pkg::XW-1:0] out_value,
  input  logic                          out_in_range,
  output int                            fail_count,
  output int                            pending,
  output int                            activity
);

  typedef struct packed {
    logic signed [tli_pkg::XW-1:0] value;
    logic                          in_range;
  } interp_result_t;

  logic signed [tli_pkg::XW-1:0] tbl_x [DEPTH];
  logic signed [tli_pkg::XW-1:0] tbl_y [DEPTH];
  logic [tli_pkg::CNT_W-1:0]     entry_count;
  interp_result_t                results_due [$];

  function automatic interp_result_t interpolate_at(input logic signed [tli_pkg::XW-1:0] qx);
    interp_result_t res;
    int n, lo, hi, mid;
    longint x, x0, x1, y0, y1, dx, dy, dq, sum;
    logic [63:0] mag_dy, mag_dq, mag_dx, quo;
    logic neg;
    n = int'(entry_count);
    if (n < int'(tli_pkg::CNT_MIN)) n = int'(tli_pkg::CNT_MIN);
    if (n > DEPTH) n = DEPTH;
    x = longint'(qx);
    res.value = '0;
    res.in_range = 1'b0;
    if (x < longint'(tbl_x[0]) || x > longint'(tbl_x[n-1])) return res;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (x > longint'(tbl_x[mid])) lo = mid;
      else hi = mid;
    end
    x0 = longint'(tbl_x[lo]);
    x1 = longint'(tbl_x[lo+1]);
    y0 = longint'(tbl_y[lo]);
    y1 = longint'(tbl_y[lo+1]);
    dx = x1 - x0;
    dy = y1 - y0;
    dq = x - x0;
    res.in_range = 1'b1;
    // zero-width segment returns the left ordinate
    if (dx == 0) begin
      res.value = y0[tli_pkg::XW-1:0];
      return res;
    end
    mag_dy = (dy < 0) ? -dy : dy;
    mag_dq = (dq < 0) ? -dq : dq;
    mag_dx = (dx < 0) ? -dx : dx;
    quo = (mag_dy * mag_dq) / mag_dx;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    if (quo == 0) neg = 1'b0;
    if (quo > 64'h1_FFFF_FFFF) begin
      res.value = neg ? tli_pkg::Q_MIN : tli_pkg::Q_MAX;
      return res;
    end
    sum = neg ? y0 - longint'(quo) : y0 + longint'(quo);
    if (sum > longint'($signed(tli_pkg::Q_MAX))) res.value = tli_pkg::Q_MAX;
    else if (sum < longint'($signed(tli_pkg::Q_MIN))) res.value = tli_pkg::Q_MIN;
    else res.value = sum[tli_pkg::XW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    interp_result_t want;
    if (!rst_n) begin
      results_due.delete();
      entry_count = tli_pkg::CNT_RESET;
      fail_count = 0;
      activity = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        activity++;
        if (results_due.size() == 0) begin
          $error("result word with none outstanding: value %0d in_range %0b",
                 out_value, out_in_range);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_in_range !== want.in_range) begin
            $error("in_range mismatch: expected %0b, got %0b", want.in_range, out_in_range);
            fail_count++;
          end
          if (out_value !== want.value) begin
            $error("value mismatch: expected %0d, got %0d", want.value, out_value);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        entry_count = cfg_entry_count;
        activity++;
      end
      if (start && !busy) begin
        activity++;
        if (in_action == tli_pkg::ACT_LOAD) begin
          if (in_entry_index < DEPTH) begin
            tbl_x[in_entry_index] = in_entry_x;
            tbl_y[in_entry_index] = in_entry_y;
          end
        end else begin
          results_due.push_back(interpolate_at(in_query_x));
        end
      end
      pending = results_due.size();
    end
  end

endmodule

>>> bench/tb.sv
// tb: top of the table interpolator bench. Drives load/query words and
// entry_count writes, gives the verdict. Depends on tli_pkg, tli_checker and
// table_linear_interpolator.
module tb;

  localparam int     DEPTH       = 1024;
  localparam int     STALL_LIMIT = 2000;
  localparam int     DRAIN       = 70;
  localparam int     N_DENSE     = 9;
  localparam int     SPARSE_LEN  = 30;
  localparam longint Q_LO        = -64'sd2147483648;
  localparam longint Q_HI        = 64'sd2147483647;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_action;
  logic [tli_pkg::IDX_W-1:0]     in_entry_index;
  logic signed [tli_pkg::XW-1:0] in_entry_x;
  logic signed [tli_pkg::XW-1:0] in_entry_y;
  logic signed [tli_pkg::XW-1:0] in_query_x;
  logic                          cfg_we;
  logic [tli_pkg::CNT_W-1:0]     cfg_entry_count;
  logic                          out_valid;
  logic signed [tli_pkg::XW-1:0] out_value;
  logic                          out_in_range;
  int                            fail_count;
  int                            pending;
  int                            activity;

  // stimulus-side copy of the abscissae, used to aim queries and to keep rewrites increasing
  logic signed [tli_pkg::XW-1:0] tx [DEPTH];
  int                            stall_cycles;
  int                            last_activity;

  table_linear_interpolator #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_entry_index(in_entry_index),
    .in_entry_x(in_entry_x), .in_entry_y(in_entry_y), .in_query_x(in_query_x),
    .cfg_we(cfg_we), .cfg_entry_count(cfg_entry_count),
    .out_valid(out_valid), .out_value(out_value), .out_in_range(out_in_range)
  );

  tli_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_entry_index(in_entry_index),
    .in_entry_x(in_entry_x), .in_entry_y(in_entry_y), .in_query_x(in_query_x),
    .cfg_we(cfg_we), .cfg_entry_count(cfg_entry_count),
    .out_valid(out_valid), .out_value(out_value), .out_in_range(out_in_range),
    .fail_count(fail_count), .pending(pending), .activity(activity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: cycles with no word moving on any channel
  always @(negedge clk) begin
    if (rst_n) begin
      if (activity != last_activity) begin
        last_activity = activity;
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  function automatic int dense_count(input int p);
    case (p)
      0:       return 2;
      1:       return 0;
      2:       return 1;
      3:       return 3;
      4:       return 5;
      5:       return 16;
      6:       return 17;
      7:       return 100;
      default: return 33;
    endcase
  endfunction

  function automatic int dense_len(input int p);
    case (p)
      0:       return 50;
      1:       return 40;
      2:       return 40;
      3:       return 50;
      4:       return 60;
      5:       return 70;
      6:       return 70;
      7:       return 60;
      default: return 60;
    endcase
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    logic [63:0] off;
    off = {$urandom, $urandom} % (hi - lo + 1);
    return lo + longint'(off);
  endfunction

  function automatic logic signed [31:0] rand_ordinate();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? tli_pkg::Q_MAX : tli_pkg::Q_MIN;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_query(input int n);
    longint lo, hi;
    int r;
    lo = longint'(tx[0]);
    hi = longint'(tx[n-1]);
    r = $urandom_range(0, 99);
    if (r < 15) return tx[$urandom_range(0, n - 1)];
    if (r < 20 && lo > Q_LO) return 32'(lo - 1);
    if (r < 25 && hi < Q_HI) return 32'(hi + 1);
    if (r < 35 || hi < lo) return $urandom;
    return 32'(rand_between(lo, hi));
  endfunction

  // word accepted at the rising edge where start is high and busy low
  task automatic send_word(input logic act, input logic [tli_pkg::IDX_W-1:0] idx,
                           input logic signed [31:0] ex, input logic signed [31:0] ey,
                           input logic signed [31:0] qx);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_entry_index <= idx;
    in_entry_x     <= ex;
    in_entry_y     <= ey;
    in_query_x     <= qx;
    @(negedge clk);
    if (act == tli_pkg::ACT_LOAD) tx[idx] = ex;
  endtask

  task automatic load(input int idx, input logic signed [31:0] ex,
                      input logic signed [31:0] ey);
    send_word(tli_pkg::ACT_LOAD, 10'(idx), ex, ey, $urandom);
  endtask

  task automatic query(input logic signed [31:0] qx);
    send_word(tli_pkg::ACT_QUERY, 10'($urandom), $urandom, $urandom, qx);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 15);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // count changes only once the block is idle and the last load has settled
  task automatic set_count(input logic [tli_pkg::CNT_W-1:0] c);
    wait_drained();
    while (busy) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_entry_count <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // strictly increasing abscissae over entries 0..n-1
  task automatic fill_table(input int n);
    longint step, max_step, base, jit;
    max_step = 64'd4294967295 / n;
    if ($urandom_range(0, 1)) step = rand_between(1, (max_step < 1000) ? max_step : 1000);
    else step = rand_between(1, max_step);
    base = rand_between(Q_LO, Q_HI - n * step + 1);
    for (int i = 0; i < n; i++) begin
      jit = rand_between(0, step - 1);
      idle_gap();
      load(i, 32'(base + i * step + jit), rand_ordinate());
    end
  endtask

  // full-depth table with only entries 0..7 and every index 2^k-1 loaded;
  // searches for x up to tx[7] only touch those
  task automatic fill_sparse();
    longint step, base, jit;
    step = rand_between(1, 64'd4294967295 / DEPTH);
    base = rand_between(Q_LO, Q_HI - DEPTH * step + 1);
    for (int i = 0; i < DEPTH; i++) begin
      if (i < 8 || ((i + 1) & i) == 0) begin
        jit = rand_between(0, step - 1);
        idle_gap();
        load(i, 32'(base + i * step + jit), rand_ordinate());
      end
    end
  endtask

  task automatic run_phase(input int n, input int len);
    int r, idx;
    longint lo_b, hi_b;
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      idle_gap();
      if (r < 70) begin
        query(pick_query(n));
      end else if (r < 85) begin
        // rewrite an entry but keep the table increasing
        idx = $urandom_range(0, n - 1);
        lo_b = (idx > 0) ? longint'(tx[idx-1]) + 1 : Q_LO;
        hi_b = (idx < n - 1) ? longint'(tx[idx+1]) - 1 : Q_HI;
        if (hi_b >= lo_b) load(idx, 32'(rand_between(lo_b, hi_b)), rand_ordinate());
        else load(idx, tx[idx], rand_ordinate());
      end else if (r < 95) begin
        load($urandom_range(0, DEPTH - 1), $urandom, $urandom);
      end else begin
        wait_drained();
      end
    end
  endtask

  // queries on the sparse table: first segments or outside the table
  task automatic run_sparse(input int len);
    int r;
    longint lo, hi, top;
    logic signed [31:0] qx;
    for (int k = 0; k < len; k++) begin
      lo  = longint'(tx[0]);
      hi  = longint'(tx[7]);
      top = longint'(tx[DEPTH-1]);
      r = $urandom_range(0, 99);
      if (r < 50) qx = 32'(rand_between(lo, hi));
      else if (r < 60) qx = tx[$urandom_range(0, 7)];
      else if (r < 75 && lo > Q_LO) qx = 32'(rand_between(Q_LO, lo - 1));
      else if (r < 90 && top < Q_HI) qx = 32'(rand_between(top + 1, Q_HI));
      else qx = tx[0];
      idle_gap();
      query(qx);
      if (r >= 95) wait_drained();
    end
  endtask

  initial begin
    int n;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = tli_pkg::ACT_LOAD;
    in_entry_index  = '0;
    in_entry_x      = '0;
    in_entry_y      = '0;
    in_query_x      = '0;
    cfg_we          = 1'b0;
    cfg_entry_count = tli_pkg::CNT_RESET;
    stall_cycles    = 0;
    last_activity   = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: entry_count is at its reset value of two
    load(0, tli_pkg::Q_MIN, 32'sh1234_5678);
    load(1, tli_pkg::Q_MAX, tli_pkg::Q_MIN);
    query(tli_pkg::Q_MIN);
    query(tli_pkg::Q_MAX);
    query(0);
    query(-1);
    load(0, 0, tli_pkg::Q_MIN);
    load(1, 1, tli_pkg::Q_MAX);
    query(1);
    // negative slope, quotient truncates toward zero
    load(0, 0, 0);
    load(1, 3, -7);
    query(1);
    query(2);
    query(-1);
    query(4);
    // zero-width segment
    load(0, 5, 100);
    load(1, 5, 200);
    query(5);
    query(4);
    query(6);

    for (int p = 0; p < N_DENSE; p++) begin
      set_count(11'(dense_count(p)));
      n = dense_count(p);
      if (n < int'(tli_pkg::CNT_MIN)) n = int'(tli_pkg::CNT_MIN);
      if (n > DEPTH) n = DEPTH;
      fill_table(n);
      run_phase(n, dense_len(p));
    end

    // counts at and above the table depth, all clamped to the full table
    set_count(11'd1024);
    fill_sparse();
    run_sparse(SPARSE_LEN);
    set_count(11'd2047);
    run_sparse(SPARSE_LEN);
    set_count(11'd1025);
    run_sparse(SPARSE_LEN);

    wait_drained();
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
